[rtl/mvps_pkg.sv]
// shared types and constants for the max-variance pivot selector
// field widths, kept-list entry type and the sequencer state encoding
// no dependencies
package mvps_pkg;

  localparam int DIST_W      = 16;
  localparam int ID_W        = 16;
  localparam int SPREAD_W    = 56;
  localparam int SLOT_W      = 6;
  localparam int CFG_W       = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 80;

  localparam int DEF_MAX_PIVOTS      = 16;
  localparam int DEF_MAX_COMPARISONS = 4096;

  // one kept candidate
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [SPREAD_W-1:0] spread;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_WALK,
    ST_FIN,
    ST_EM_RD,
    ST_EM_LD
  } state_t;

endpackage

[rtl/max_variance_pivot_select_core.sv]
// max-variance pivot selector: accumulates distance moments per candidate,
// keeps the top spreads in a sorted list held in a ram with a registered read port
// depends on mvps_pkg
//
// A distance word that does not close a candidate is accumulated in ST_IDLE.
// A word with in_tlast (end of candidate) or in_tuser (end of sample) set
// snapshots the moments when it is accepted; ST_MUL and ST_SUB then form
// n*sumsq - sum^2 (split multiply, subtract), ST_WALK walks the kept entries
// from the tail of the list toward the insertion point (at most
// min(filled, effective pivot_count) entries), and ST_FIN places the new
// entry when it ranks inside the list; the walk speed is set by the single
// read port of the list ram, which reads one entry per cycle while the write
// port shifts the previous one down. At end of sample ST_EM_RD issues the
// first ram read, after which the ranked pivots leave at one word per cycle
// while out_tready is high; the input is held off until the last pivot has
// been loaded into the output register. The list ram needs no clearing pass:
// only entries below the fill count are ever read.
module max_variance_pivot_select_core #(
  parameter int MAX_PIVOTS      = mvps_pkg::DEF_MAX_PIVOTS,
  parameter int MAX_COMPARISONS = mvps_pkg::DEF_MAX_COMPARISONS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration: pivot_count
  input  logic                             cfg_wr_en,
  input  logic [mvps_pkg::CFG_W-1:0]       cfg_wr_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mvps_pkg::IN_TDATA_W-1:0]  in_tdata,   // distance, candidate_id
  input  logic                             in_tlast,   // last_of_candidate
  input  logic                             in_tuser,   // last_of_sample
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mvps_pkg::OUT_TDATA_W-1:0] out_tdata,  // pivot_slot, pivot_id, spread, 2'b0
  output logic                             out_tlast   // last_pivot
);
  import mvps_pkg::*;

  localparam int IDX_W    = (MAX_PIVOTS > 1) ? $clog2(MAX_PIVOTS) : 1;
  localparam int CNT_W    = $clog2(MAX_PIVOTS + 1);
  localparam int LOG_CMP  = $clog2(MAX_COMPARISONS);
  localparam int CMP_W    = $clog2(MAX_COMPARISONS + 1);
  localparam int SUM_W    = DIST_W + LOG_CMP;
  localparam int SQ_W     = 2 * DIST_W + LOG_CMP;
  localparam int SQ_LO_W  = (SQ_W + 1) / 2;
  localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
  localparam int PLO_W    = CMP_W + SQ_LO_W;
  localparam int PHI_W    = CMP_W + SQ_HI_W;
  localparam int SS_W     = 2 * SUM_W;

  // ---------------- registers ----------------
  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     pivot_count_r, pivot_count_nxt;
  logic [SUM_W-1:0]     dsum_r, dsum_nxt;
  logic [SQ_W-1:0]      sqsum_r, sqsum_nxt;
  logic [CMP_W-1:0]     ncmp_r, ncmp_nxt;
  logic [CNT_W-1:0]     filled_r, filled_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [CMP_W-1:0]     snap_n_r, snap_n_nxt;
  logic [SUM_W-1:0]     snap_s_r, snap_s_nxt;
  logic [SQ_W-1:0]      snap_q_r, snap_q_nxt;
  logic [ID_W-1:0]      snap_id_r, snap_id_nxt;
  logic                 snap_eos_r, snap_eos_nxt;
  logic [PLO_W-1:0]     p1_r, p1_nxt;
  logic [PHI_W-1:0]     p2_r, p2_nxt;
  logic [SS_W-1:0]      p3_r, p3_nxt;
  logic [SPREAD_W-1:0]  spread_r, spread_nxt;
  logic [CNT_W-1:0]     len_r, len_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [IDX_W-1:0]     emit_last_r, emit_last_nxt;
  logic [IDX_W-1:0]     out_slot_r, out_slot_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic [SPREAD_W-1:0]  out_spread_r, out_spread_nxt;
  logic                 out_last_r, out_last_nxt;

  // ---------------- kept-list ram ----------------
  entry_t               mem [MAX_PIVOTS];
  entry_t               rdata_r;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  entry_t               mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // ---------------- datapath helpers ----------------
  logic [CNT_W-1:0]      k_eff;
  logic [DIST_W-1:0]     dist_in;
  logic [2*DIST_W-1:0]   dist_sq;
  logic                  in_acc, out_acc, room, closing, out_free;
  logic [SUM_W-1:0]      dsum_acc;
  logic [SQ_W-1:0]       sqsum_acc;
  logic [CMP_W-1:0]      ncmp_acc;
  logic [CNT_W-1:0]      filled_fin;

  always_comb begin
    if (pivot_count_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (pivot_count_r > CFG_W'(MAX_PIVOTS)) begin
      k_eff = CNT_W'(MAX_PIVOTS);
    end else begin
      k_eff = CNT_W'(pivot_count_r);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign dist_in   = in_tdata[DIST_W-1:0];
  assign dist_sq   = dist_in * dist_in;
  assign closing   = in_tlast || in_tuser;
  // distances past the comparison limit are dropped
  assign room      = ncmp_r < CMP_W'(MAX_COMPARISONS);

  always_comb begin
    if (room) begin
      dsum_acc  = dsum_r + SUM_W'(dist_in);
      sqsum_acc = sqsum_r + SQ_W'(dist_sq);
      ncmp_acc  = ncmp_r + CMP_W'(1);
    end else begin
      dsum_acc  = dsum_r;
      sqsum_acc = sqsum_r;
      ncmp_acc  = ncmp_r;
    end
  end

  assign filled_fin = (pos_r < k_eff) ? ((len_r < k_eff) ? len_r + CNT_W'(1) : k_eff)
                                      : len_r;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt       = state_r;
    pivot_count_nxt = cfg_wr_en ? cfg_wr_data : pivot_count_r;
    dsum_nxt        = dsum_r;
    sqsum_nxt       = sqsum_r;
    ncmp_nxt        = ncmp_r;
    filled_nxt      = filled_r;
    out_valid_nxt   = out_acc ? 1'b0 : out_valid_r;
    snap_n_nxt      = snap_n_r;
    snap_s_nxt      = snap_s_r;
    snap_q_nxt      = snap_q_r;
    snap_id_nxt     = snap_id_r;
    snap_eos_nxt    = snap_eos_r;
    p1_nxt          = p1_r;
    p2_nxt          = p2_r;
    p3_nxt          = p3_r;
    spread_nxt      = spread_r;
    len_nxt         = len_r;
    cur_nxt         = cur_r;
    pos_nxt         = pos_r;
    slot_nxt        = slot_r;
    emit_last_nxt   = emit_last_r;
    out_slot_nxt    = out_slot_r;
    out_id_nxt      = out_id_r;
    out_spread_nxt  = out_spread_r;
    out_last_nxt    = out_last_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = '0;
    mem_raddr       = '0;
    mem_wdata       = rdata_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (closing) begin
            snap_n_nxt   = ncmp_acc;
            snap_s_nxt   = dsum_acc;
            snap_q_nxt   = sqsum_acc;
            snap_id_nxt  = in_tdata[DIST_W +: ID_W];
            snap_eos_nxt = in_tuser;
            dsum_nxt     = '0;
            sqsum_nxt    = '0;
            ncmp_nxt     = '0;
            state_nxt    = ST_MUL;
          end else begin
            dsum_nxt  = dsum_acc;
            sqsum_nxt = sqsum_acc;
            ncmp_nxt  = ncmp_acc;
          end
        end
      end
      ST_MUL: begin
        // n*sumsq split into two narrow products
        p1_nxt    = PLO_W'(snap_n_r) * PLO_W'(snap_q_r[SQ_LO_W-1:0]);
        p2_nxt    = PHI_W'(snap_n_r) * PHI_W'(snap_q_r[SQ_W-1:SQ_LO_W]);
        p3_nxt    = SS_W'(snap_s_r) * SS_W'(snap_s_r);
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        spread_nxt = SPREAD_W'(p1_r) + (SPREAD_W'(p2_r) << SQ_LO_W) - SPREAD_W'(p3_r);
        len_nxt    = (filled_r < k_eff) ? filled_r : k_eff;
        if (len_nxt == '0) begin
          pos_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          // start at the tail of the list
          cur_nxt   = IDX_W'(len_nxt - CNT_W'(1));
          mem_re    = 1'b1;
          mem_raddr = cur_nxt;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // ties stay ahead of the newcomer
        if (rdata_r.spread >= spread_r) begin
          pos_nxt   = CNT_W'(cur_r) + CNT_W'(1);
          state_nxt = ST_FIN;
        end else begin
          if (CNT_W'(cur_r) + CNT_W'(1) < k_eff) begin
            mem_we    = 1'b1;
            mem_waddr = cur_r + IDX_W'(1);
            mem_wdata = rdata_r;
          end
          if (cur_r == '0) begin
            pos_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            // next read never hits the slot being written
            cur_nxt   = cur_r - IDX_W'(1);
            mem_re    = 1'b1;
            mem_raddr = cur_nxt;
          end
        end
      end
      ST_FIN: begin
        if (pos_r < k_eff) begin
          mem_we           = 1'b1;
          mem_waddr        = IDX_W'(pos_r);
          mem_wdata.id     = snap_id_r;
          mem_wdata.spread = spread_r;
        end
        if (snap_eos_r) begin
          emit_last_nxt = IDX_W'(filled_fin - CNT_W'(1));
          slot_nxt      = '0;
          filled_nxt    = '0;
          state_nxt     = ST_EM_RD;
        end else begin
          filled_nxt = filled_fin;
          state_nxt  = ST_IDLE;
        end
      end
      ST_EM_RD: begin
        mem_re    = 1'b1;
        mem_raddr = slot_r;
        state_nxt = ST_EM_LD;
      end
      ST_EM_LD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = slot_r;
          out_id_nxt     = rdata_r.id;
          out_spread_nxt = rdata_r.spread;
          out_last_nxt   = (slot_r == emit_last_r);
          if (slot_r == emit_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt  = slot_r + IDX_W'(1);
            mem_re    = 1'b1;
            mem_raddr = slot_nxt;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pivot_count_r <= CFG_W'(1);
      dsum_r        <= '0;
      sqsum_r       <= '0;
      ncmp_r        <= '0;
      filled_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pivot_count_r <= pivot_count_nxt;
      dsum_r        <= dsum_nxt;
      sqsum_r       <= sqsum_nxt;
      ncmp_r        <= ncmp_nxt;
      filled_r      <= filled_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_n_r     <= snap_n_nxt;
    snap_s_r     <= snap_s_nxt;
    snap_q_r     <= snap_q_nxt;
    snap_id_r    <= snap_id_nxt;
    snap_eos_r   <= snap_eos_nxt;
    p1_r         <= p1_nxt;
    p2_r         <= p2_nxt;
    p3_r         <= p3_nxt;
    spread_r     <= spread_nxt;
    len_r        <= len_nxt;
    cur_r        <= cur_nxt;
    pos_r        <= pos_nxt;
    slot_r       <= slot_nxt;
    emit_last_r  <= emit_last_nxt;
    out_slot_r   <= out_slot_nxt;
    out_id_r     <= out_id_nxt;
    out_spread_r <= out_spread_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W - SPREAD_W - ID_W - SLOT_W)'(0),
                       out_spread_r, out_id_r, SLOT_W'(out_slot_r)};

  // ---------------- assertions ----------------
  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(MAX_PIVOTS))
    else $error("fill count beyond list depth");

  a_cmp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ncmp_r <= CMP_W'(MAX_COMPARISONS))
    else $error("comparison count beyond limit");

  a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("list ram read and write hit the same entry");

  a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (CNT_W'(cur_r) < len_r))
    else $error("insertion walk left the filled part of the list");

endmodule

[test/tb_max_variance_pivot_select_core.sv]
// self-checking bench for max_variance_pivot_select_core: directed table, long receiver
// hold-off and random samples, each result checked against a behavioral top-k tracker or
// the typed row's own expectation; depends on mvps_pkg and the core rtl
module tb_max_variance_pivot_select_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mvps_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_WORDS  = 340;
  localparam logic [7:0] NO_WRITE = 8'hFF;

  typedef struct {
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     id;
    logic [SPREAD_W-1:0] spread;
    logic                last;
  } pivot_t;

  // one directed row: optional pivot_count write first, then the word
  typedef struct packed {
    logic [7:0]          cfg;
    logic [DIST_W-1:0]   dval;
    logic [ID_W-1:0]     id;
    logic                end_cand;
    logic                end_sample;
    logic                typed;
    logic [ID_W-1:0]     top_id;
    logic [SPREAD_W-1:0] top_spread;
  } row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // distance, candidate_id
  logic                   in_tlast;    // last_of_candidate
  logic                   in_tuser;    // last_of_sample
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // pivot_slot, pivot_id, spread, 2'b0
  logic                   out_tlast;   // last_pivot

  max_variance_pivot_select_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // behavioral copy of the selector state
  logic [CFG_W-1:0]    pivot_count_q;
  logic [27:0]         moment_sum;
  logic [43:0]         moment_sq;
  logic [12:0]         moment_n;
  logic [ID_W-1:0]     rank_id[DEF_MAX_PIVOTS];
  logic [SPREAD_W-1:0] rank_spread[DEF_MAX_PIVOTS];
  int unsigned         rank_len;

  pivot_t expected_pivots[$];
  row_t   directed_rows[$];
  int     errors;
  int     words_sent;
  int     words_taken = 0;
  bit     tx_burst;
  bit     rx_burst;
  bit     long_hold_req;
  int     stall_left;

  function automatic void expect_pivot(pivot_t p);
    expected_pivots = {expected_pivots, p};
  endfunction

  function automatic void add_row(row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  function automatic int unsigned kept_limit();
    int unsigned k;
    k = pivot_count_q;
    if (k == 0) k = 1;
    if (k > DEF_MAX_PIVOTS) k = DEF_MAX_PIVOTS;
    return k;
  endfunction

  // advance the tracker by one accepted word; queue emitted pivots unless a typed row
  // supplies its own expectation
  function automatic void track_word(logic [DIST_W-1:0] dval, logic [ID_W-1:0] id,
                                     logic end_cand, logic end_sample, bit push);
    logic [63:0] sp;
    int unsigned k;
    int unsigned len;
    int unsigned pos;
    int unsigned i;
    pivot_t p;
    if (moment_n < DEF_MAX_COMPARISONS) begin
      moment_sum = moment_sum + 28'(dval);
      moment_sq  = moment_sq + 44'(32'(dval) * 32'(dval));
      moment_n   = moment_n + 13'd1;
    end
    if (end_cand || end_sample) begin
      sp  = 64'(moment_n) * 64'(moment_sq) - 64'(moment_sum) * 64'(moment_sum);
      k   = kept_limit();
      len = (rank_len < k) ? rank_len : k;
      pos = 0;
      while (pos < len && rank_spread[pos] >= sp[SPREAD_W-1:0]) pos++;
      if (pos >= k) begin
        rank_len = len;
      end else begin
        i = (len < k) ? len : k - 1;
        while (i > pos) begin
          rank_id[i]     = rank_id[i-1];
          rank_spread[i] = rank_spread[i-1];
          i--;
        end
        rank_id[pos]     = id;
        rank_spread[pos] = sp[SPREAD_W-1:0];
        rank_len = (len + 1 < k) ? len + 1 : k;
      end
      moment_sum = '0;
      moment_sq  = '0;
      moment_n   = '0;
    end
    if (end_sample) begin
      k   = kept_limit();
      len = (rank_len < k) ? rank_len : k;
      for (i = 0; i < len; i++) begin
        p.slot   = SLOT_W'(i);
        p.id     = rank_id[i];
        p.spread = rank_spread[i];
        p.last   = (i + 1 == len);
        if (push) expect_pivot(p);
      end
      rank_len = 0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    pivot_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pivots.size() == 0) begin
        report_mismatch("unexpected word, pivot_id", 64'(out_tdata[21:6]), 64'd0);
      end else begin
        w = expected_pivots.pop_front();
        if (out_tdata[5:0] !== w.slot)
          report_mismatch("pivot_slot", 64'(out_tdata[5:0]), 64'(w.slot));
        if (out_tdata[21:6] !== w.id)
          report_mismatch("pivot_id", 64'(out_tdata[21:6]), 64'(w.id));
        if (out_tdata[77:22] !== w.spread)
          report_mismatch("spread", 64'(out_tdata[77:22]), 64'(w.spread));
        if (out_tlast !== w.last)
          report_mismatch("last_pivot", 64'(out_tlast), 64'(w.last));
      end
      words_taken++;
    end
  end

  // ready driver, draws the stall after each taken word and owns the long hold-off count
  initial begin
    int seen;
    bit hold_taken;
    seen       = 0;
    hold_taken = 1'b0;
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (words_taken != seen) begin
        seen       = words_taken;
        stall_left = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (!rst_n) begin
        out_tready = 1'b0;
      end else if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_tready = 1'b1;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_word(logic [DIST_W-1:0] dval, logic [ID_W-1:0] id, logic end_cand,
                           logic end_sample, bit typed = 0, logic [ID_W-1:0] top_id = '0,
                           logic [SPREAD_W-1:0] top_spread = '0);
    int gap;
    pivot_t p;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {id, dval};
    in_tlast  = end_cand;
    in_tuser  = end_sample;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_word(dval, id, end_cand, end_sample, !typed);
    if (typed) begin
      p.slot   = '0;
      p.id     = top_id;
      p.spread = top_spread;
      p.last   = 1'b1;
      expect_pivot(p);
    end
    words_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // block is quiet: no result pending and any list walk has finished
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (expected_pivots.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_pivot_count(logic [CFG_W-1:0] v);
    cfg_wr_data = v;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    pivot_count_q = v;
  endtask

  function automatic logic [CFG_W-1:0] pick_pivot_count();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd16;
      3:       return 7'd17;
      4:       return 7'd64;
      5:       return 7'd127;
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance(int mode, logic [DIST_W-1:0] base);
    case (mode)
      0:       return DIST_W'($urandom);
      1:       return DIST_W'($urandom_range(0, 15));
      2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return base;
    endcase
  endfunction

  task automatic run_sample(int n_cand);
    int len;
    int mode;
    logic [ID_W-1:0] id;
    logic [DIST_W-1:0] base;
    for (int c = 0; c < n_cand; c++) begin
      id   = ID_W'($urandom);
      len  = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
      mode = $urandom_range(0, 3);
      // mode 3 repeats a fixed pair so spreads tie across candidates
      base = DIST_W'($urandom_range(0, 3) * 1000);
      for (int j = 0; j < len; j++) begin
        if (j == len - 1) begin
          if (c == n_cand - 1)
            send_word(pick_distance(mode, base), id, 1'($urandom_range(0, 1)), 1'b1);
          else
            send_word(pick_distance(mode, base), id, 1'b1, 1'b0);
        end else begin
          send_word(pick_distance(mode, base + DIST_W'(j[0] * 500)), id, 1'b0, 1'b0);
        end
      end
      if (c != n_cand - 1 && $urandom_range(0, 11) == 0) begin
        // pivot count change in the middle of a sample
        wait_idle();
        write_pivot_count(pick_pivot_count());
      end
    end
  endtask

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    in_tuser      = 1'b0;
    errors        = 0;
    words_sent    = 0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    long_hold_req = 1'b0;
    pivot_count_q = 7'd1;
    moment_sum    = '0;
    moment_sq     = '0;
    moment_n      = '0;
    rank_len      = 0;
    for (int i = 0; i < DEF_MAX_PIVOTS; i++) begin
      rank_id[i]     = '0;
      rank_spread[i] = '0;
    end

    // cfg, distance, id, last_of_candidate, last_of_sample, typed, top id, top spread
    add_row('{NO_WRITE, 16'd0,     16'h0000, 1'b0, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd65535, 16'hFFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 56'hFFFE0001});
    // single distance: zero spread
    add_row('{NO_WRITE, 16'd12345, 16'h1234, 1'b1, 1'b1, 1'b1, 16'h1234, 56'd0});
    // pivot count 0 behaves as 1
    add_row('{8'd0,     16'd100,   16'h0001, 1'b0, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd300,   16'h0001, 1'b1, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd5,     16'h0002, 1'b1, 1'b1, 1'b1, 16'h0001, 56'd40000});
    // above the maximum clamps; equal spreads keep arrival order; sample end alone closes
    add_row('{8'd127,   16'd0,     16'h0010, 1'b0, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd10,    16'h0010, 1'b1, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd20,    16'h0020, 1'b0, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd30,    16'h0020, 1'b1, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd7,     16'h0030, 1'b1, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd65535, 16'hAAAA, 1'b0, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd0,     16'hAAAA, 1'b0, 1'b1, 1'b0, 16'h0, 56'd0});
    // list filled at three, then shrunk to two before the sample ends
    add_row('{8'd3,     16'd1000,  16'h0100, 1'b1, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd0,     16'h0200, 1'b0, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd4000,  16'h0200, 1'b1, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd9,     16'h0300, 1'b0, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd2,     16'h0300, 1'b1, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{8'd2,     16'd50000, 16'h0400, 1'b0, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd1,     16'h0400, 1'b1, 1'b1, 1'b0, 16'h0, 56'd0});
    add_row('{8'd64,    16'd43690, 16'hBEEF, 1'b0, 1'b0, 1'b0, 16'h0, 56'd0});
    add_row('{NO_WRITE, 16'd21845, 16'hBEEF, 1'b1, 1'b1, 1'b0, 16'h0, 56'd0});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].cfg != NO_WRITE) begin
        wait_idle();
        write_pivot_count(directed_rows[r].cfg[CFG_W-1:0]);
      end
      send_word(directed_rows[r].dval, directed_rows[r].id, directed_rows[r].end_cand,
                directed_rows[r].end_sample, directed_rows[r].typed,
                directed_rows[r].top_id, directed_rows[r].top_spread);
    end
    wait_idle();

    // receiver holds off while samples keep coming, so the core backs up
    tx_burst = 1'b0;
    long_hold_req = 1'b1;
    repeat (3) run_sample(8);
    rx_burst = 1'b0;
    wait_idle();

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        write_pivot_count(pick_pivot_count());
      end else if ($urandom_range(0, 3) == 0) begin
        wait_idle();
      end
      run_sample(($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8));
    end

    in_tvalid = 1'b0;
    while (expected_pivots.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
